// ===== rtl/srv_pkg.sv =====
// ----------------------------------------------------------------------------
// srv_pkg
// Constants, types and CRC helper shared by the request validator.
// ----------------------------------------------------------------------------
package srv_pkg;

    localparam int MAX_MESSAGE_BYTES = 2048;
    localparam int FRAG_MAX_BYTES    = 8;
    localparam int IDX_W             = 12;

    localparam logic [31:0] STUN_COOKIE      = 32'h2112A442;
    localparam logic [31:0] FP_XOR           = 32'h5354554e;
    localparam logic [15:0] ATTR_USERNAME    = 16'h0006;
    localparam logic [15:0] ATTR_INTEGRITY   = 16'h0008;
    localparam logic [15:0] ATTR_USE_CAND    = 16'h0025;
    localparam logic [15:0] ATTR_FINGERPRINT = 16'h8028;
    localparam logic [15:0] ATTR_CONTROLLED  = 16'h8029;
    localparam logic [IDX_W-1:0] HEADER_BYTES = 12'd20;

    typedef enum logic [1:0] {
        CFG_LOCAL_BYTES  = 2'd0,
        CFG_LOCAL_LEN    = 2'd1,
        CFG_REMOTE_BYTES = 2'd2,
        CFG_REMOTE_LEN   = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_COOKIE    = 3'd2,
        ST_TRUNC     = 3'd3,
        ST_USERNAME  = 3'd4,
        ST_FPRINT    = 3'd5,
        ST_CONTROLLED = 3'd6,
        ST_TOO_LONG  = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_ATTR_HDR = 2'd1,
        PH_VALUE = 2'd2
    } t_phase;

    typedef struct packed {
        logic [63:0] local_bytes;
        logic [3:0]  local_len;
        logic [63:0] remote_bytes;
        logic [3:0]  remote_len;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  status;
        logic        use_candidate;
        logic        integrity_present;
        logic [10:0] integrity_offset;
        logic        fingerprint_present;
        logic [11:0] message_bytes;
        logic [15:0] message_kind;
        logic [31:0] txid_upper;
        logic [63:0] txid_lower;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (32'hEDB88320 & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== rtl/srv_config.sv =====
// ----------------------------------------------------------------------------
// srv_config
// Ufrag register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module srv_config (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output srv_pkg::t_cfg o_cfg
);
    srv_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (srv_pkg::t_cfg_index'(i_cfg_index))
                srv_pkg::CFG_LOCAL_BYTES:  r_cfg.local_bytes  <= i_cfg_data;
                srv_pkg::CFG_LOCAL_LEN:    r_cfg.local_len    <= i_cfg_data[3:0];
                srv_pkg::CFG_REMOTE_BYTES: r_cfg.remote_bytes <= i_cfg_data;
                srv_pkg::CFG_REMOTE_LEN:   r_cfg.remote_len   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end
endmodule

// ===== rtl/srv_parser.sv =====
// ----------------------------------------------------------------------------
// srv_parser
// Byte-wise message parser: header, attribute walk, CRC and result build.
// ----------------------------------------------------------------------------
module srv_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  srv_pkg::t_cfg i_cfg,
    output srv_pkg::t_result o_result
);
    logic [11:0] r_idx, n_idx;
    srv_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_akind, n_akind, r_alen, n_alen, r_apos, n_apos;
    logic [31:0] r_crc, n_crc, r_crc_attr, n_crc_attr, r_fpw, n_fpw;
    logic        r_prefix, n_prefix;
    logic [63:0] r_tail, n_tail;
    logic [7:0]  r_txid [12];
    logic [2:0]  r_err, n_err, r_seen, n_seen;
    logic [10:0] r_ipos, n_ipos;
    logic [15:0] r_kind, n_kind;

    logic [3:0]  ll, rl;
    logic [16:0] padded;
    logic [63:0] rmask;
    logic [5:0]  shamt;
    logic [7:0]  want;
    logic [16:0] p1;
    logic [31:0] fpw_sh;
    logic [2:0]  st;
    logic [11:0] txsel;

    assign ll = (i_cfg.local_len > 4'(srv_pkg::FRAG_MAX_BYTES)) ?
                4'(srv_pkg::FRAG_MAX_BYTES) : i_cfg.local_len;
    assign rl = (i_cfg.remote_len > 4'(srv_pkg::FRAG_MAX_BYTES)) ?
                4'(srv_pkg::FRAG_MAX_BYTES) : i_cfg.remote_len;
    assign rmask = (rl >= 4'd8) ? '1 : ((64'd1 << {rl[2:0], 3'd0}) - 64'd1);

    always_comb begin
        logic finish;
        logic [15:0] dl;
        logic [16:0] pad_c;
        n_idx = r_idx; n_phase = r_phase; n_akind = r_akind; n_alen = r_alen;
        n_apos = r_apos; n_crc = r_crc; n_crc_attr = r_crc_attr; n_fpw = r_fpw;
        n_prefix = r_prefix; n_tail = r_tail; n_err = r_err; n_seen = r_seen;
        n_ipos = r_ipos; n_kind = r_kind;
        finish = 1'b0; dl = r_alen; pad_c = '0;
        padded = ({1'b0, r_alen} + 17'd3) & ~17'd3;
        shamt = 6'd56 - {r_apos[2:0], 3'd0};
        want = 8'(i_cfg.local_bytes >> shamt);
        p1 = {1'b0, r_apos} + 17'd1;
        fpw_sh = {r_fpw[23:0], i_byte};
        txsel = r_idx - 12'd8;
        if (r_idx >= 12'(srv_pkg::MAX_MESSAGE_BYTES)) begin
            if (n_err == srv_pkg::ST_OK) n_err = srv_pkg::ST_TOO_LONG;
        end else begin
            n_crc = srv_pkg::crc_byte(r_crc, i_byte);
            n_idx = r_idx + 12'd1;
            unique case (r_phase)
                srv_pkg::PH_HEADER: begin
                    if (r_idx < 12'd2) n_kind = {r_kind[7:0], i_byte};
                    else if (r_idx >= 12'd4 && r_idx < 12'd8) begin
                        n_fpw = fpw_sh;
                        if (r_idx == 12'd7 && fpw_sh != srv_pkg::STUN_COOKIE &&
                            n_err == srv_pkg::ST_OK) n_err = srv_pkg::ST_COOKIE;
                    end
                    if (n_idx >= srv_pkg::HEADER_BYTES) begin
                        n_phase = srv_pkg::PH_ATTR_HDR; n_apos = '0; n_fpw = '0;
                    end
                end
                srv_pkg::PH_ATTR_HDR: begin
                    if (r_apos == 16'd0) n_crc_attr = r_crc;
                    if (r_apos < 16'd2) n_akind = {r_akind[7:0], i_byte};
                    else n_alen = {r_alen[7:0], i_byte};
                    n_apos = r_apos + 16'd1;
                    if (r_apos == 16'd3) begin
                        dl = n_alen;
                        n_apos = '0; n_prefix = 1'b1; n_tail = '0; n_fpw = '0;
                        if (n_akind == srv_pkg::ATTR_USE_CAND) n_seen[0] = 1'b1;
                        if (n_akind == srv_pkg::ATTR_INTEGRITY) begin
                            n_seen[1] = 1'b1; n_ipos = 11'(r_idx - 12'd3);
                        end
                        if (n_akind == srv_pkg::ATTR_CONTROLLED && n_err == srv_pkg::ST_OK)
                            n_err = srv_pkg::ST_CONTROLLED;
                        if (n_alen == 16'd0) finish = 1'b1;
                        pad_c = ({1'b0, n_alen} + 17'd3) & ~17'd3;
                        n_phase = (pad_c != 17'd0) ? srv_pkg::PH_VALUE : srv_pkg::PH_ATTR_HDR;
                    end
                end
                default: begin
                    if (r_apos < r_alen) begin
                        if (r_akind == srv_pkg::ATTR_USERNAME) begin
                            if (r_apos < {12'd0, ll} && want != i_byte) n_prefix = 1'b0;
                            n_tail = {r_tail[55:0], i_byte};
                        end
                        if (r_akind == srv_pkg::ATTR_FINGERPRINT && r_apos < 16'd4) begin
                            n_fpw = fpw_sh;
                            if (r_apos == 16'd3) begin
                                if (fpw_sh == (~r_crc_attr ^ srv_pkg::FP_XOR)) n_seen[2] = 1'b1;
                                else if (n_err == srv_pkg::ST_OK) n_err = srv_pkg::ST_FPRINT;
                            end
                        end
                        if (p1 == {1'b0, r_alen}) finish = 1'b1;
                    end
                    n_apos = r_apos + 16'd1;
                    if (p1 >= padded) begin
                        n_phase = srv_pkg::PH_ATTR_HDR; n_apos = '0;
                    end
                end
            endcase
            if (finish) begin
                if (n_akind == srv_pkg::ATTR_USERNAME &&
                    !(n_prefix && dl >= {12'd0, ll} && dl >= {12'd0, rl} &&
                      ((n_tail ^ i_cfg.remote_bytes) & rmask) == 64'd0) &&
                    n_err == srv_pkg::ST_OK) n_err = srv_pkg::ST_USERNAME;
                if (n_akind == srv_pkg::ATTR_FINGERPRINT && dl < 16'd4 &&
                    n_err == srv_pkg::ST_OK) n_err = srv_pkg::ST_FPRINT;
            end
        end
        if (n_err != srv_pkg::ST_OK) st = n_err;
        else if (n_idx < srv_pkg::HEADER_BYTES) st = srv_pkg::ST_SHORT;
        else if (n_phase == srv_pkg::PH_VALUE ||
                 (n_phase == srv_pkg::PH_ATTR_HDR && n_apos != 16'd0)) st = srv_pkg::ST_TRUNC;
        else st = srv_pkg::ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_idx <= '0; r_phase <= srv_pkg::PH_HEADER; r_akind <= '0; r_alen <= '0;
            r_apos <= '0; r_crc <= '1; r_crc_attr <= '1; r_fpw <= '0; r_prefix <= 1'b1;
            r_tail <= '0; r_err <= '0; r_seen <= '0; r_ipos <= '0; r_kind <= '0;
        end else if (i_step) begin
            r_idx <= n_idx; r_phase <= n_phase; r_akind <= n_akind; r_alen <= n_alen;
            r_apos <= n_apos; r_crc <= n_crc; r_crc_attr <= n_crc_attr; r_fpw <= n_fpw;
            r_prefix <= n_prefix; r_tail <= n_tail; r_err <= n_err; r_seen <= n_seen;
            r_ipos <= n_ipos; r_kind <= n_kind;
        end
    end

    // txid bytes written by index; no reset needed, masked until header complete
    always_ff @(posedge i_clk) begin
        if (i_step && r_phase == srv_pkg::PH_HEADER && r_idx >= 12'd8 &&
            r_idx < srv_pkg::HEADER_BYTES) r_txid[txsel[3:0]] <= i_byte;
    end

    always_comb begin
        logic [7:0] tx [12];
        logic hdr_done;
        for (int k = 0; k < 12; k++) tx[k] = r_txid[k];
        if (i_step && r_phase == srv_pkg::PH_HEADER && r_idx >= 12'd8 &&
            r_idx < srv_pkg::HEADER_BYTES) tx[txsel[3:0]] = i_byte;
        hdr_done = n_idx >= srv_pkg::HEADER_BYTES;
        o_result.status = st;
        o_result.use_candidate = n_seen[0];
        o_result.integrity_present = n_seen[1];
        o_result.integrity_offset = n_ipos;
        o_result.fingerprint_present = n_seen[2];
        o_result.message_bytes = n_idx;
        o_result.message_kind = (n_idx >= 12'd2) ? n_kind : 16'd0;
        o_result.txid_upper = hdr_done ? {tx[0], tx[1], tx[2], tx[3]} : 32'd0;
        o_result.txid_lower = hdr_done ?
            {tx[4], tx[5], tx[6], tx[7], tx[8], tx[9], tx[10], tx[11]} : 64'd0;
    end
endmodule

// ===== rtl/stun_request_validator.sv =====
// ----------------------------------------------------------------------------
// stun_request_validator
// STUN request checker: header, ufrag, fingerprint and role rules.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle while o_stall is low, no gaps needed; each
// byte updates the CRC and parser state. One result is registered after the
// final byte and held in an output register; the next message may start while
// that result waits, and input stalls only if a second result would arrive
// while the first is still held. Configuration is always ready.
module stun_request_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_message_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic        o_use_candidate,
    output logic        o_integrity_present,
    output logic [10:0] o_integrity_offset,
    output logic        o_fingerprint_present,
    output logic [11:0] o_message_bytes,
    output logic [15:0] o_message_kind,
    output logic [31:0] o_txid_upper,
    output logic [63:0] o_txid_lower,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    srv_pkg::t_cfg    cfg;
    srv_pkg::t_result res;
    srv_pkg::t_result r_res;
    logic r_valid;
    logic step;

    // stall only on a final byte while a result is still held
    assign o_stall = r_valid && i_stall && i_final_byte;
    assign step = i_valid && !o_stall;

    srv_config u_cfg (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_cfg(cfg)
    );

    srv_parser u_parse (
        .i_clk, .i_rst_n, .i_step(step), .i_byte(i_message_byte),
        .i_last(i_final_byte), .i_cfg(cfg), .o_result(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (step && i_final_byte) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && i_final_byte) r_res <= res;
    end

    assign o_valid = r_valid;
    assign o_status = r_res.status;
    assign o_use_candidate = r_res.use_candidate;
    assign o_integrity_present = r_res.integrity_present;
    assign o_integrity_offset = r_res.integrity_offset;
    assign o_fingerprint_present = r_res.fingerprint_present;
    assign o_message_bytes = r_res.message_bytes;
    assign o_message_kind = r_res.message_kind;
    assign o_txid_upper = r_res.txid_upper;
    assign o_txid_lower = r_res.txid_lower;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("held result changed");
    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == srv_pkg::ST_OK |-> o_message_bytes >= 12'd20)
        else $error("ok status on short message");
    a_fp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fingerprint_present |-> o_message_bytes >= 12'd28)
        else $error("fingerprint flag without room");
endmodule
